FILE: src/fixed_capacity_list_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-capacity list engine
// Immediate-implication and next-cycle-implication checks, reset-gated.
// ----------------------------------------------------------------------------
`ifndef FIXED_CAPACITY_LIST_ENGINE_CORE_ASSERT_SVH
`define FIXED_CAPACITY_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fcl_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int IDX_W     = 6;
    localparam int TOT_W     = 7;

    // request command codes
    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_PREPEND = 3'd1;
    localparam logic [2:0] CMD_SORTED  = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_SEARCH  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // datapath operations
    localparam logic [3:0] DP_NOP       = 4'd0;
    localparam logic [3:0] DP_LOAD      = 4'd1;
    localparam logic [3:0] DP_SCAN_INIT = 4'd2;
    localparam logic [3:0] DP_SCAN      = 4'd3;
    localparam logic [3:0] DP_GAP_INIT  = 4'd4;
    localparam logic [3:0] DP_SHIFT     = 4'd5;
    localparam logic [3:0] DP_PLACE     = 4'd6;
    localparam logic [3:0] DP_MARK      = 4'd7;
    localparam logic [3:0] DP_TAKE_LAST = 4'd8;
    localparam logic [3:0] DP_MOVE      = 4'd9;
    localparam logic [3:0] DP_POST      = 4'd10;

    // gap position select
    localparam logic [1:0] PS_ZERO = 2'd0;
    localparam logic [1:0] PS_HIT  = 2'd1;
    localparam logic [1:0] PS_TOP  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] found_index;
        logic [TOT_W-1:0] entry_total;
    } t_out;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] pos_sel;
        logic       cmp_ge;
        logic [1:0] status;
        logic       idx_en;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic scan_hit;
        logic scan_done;
        logic shift_done;
        logic any_hit;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: src/fcl_ctrl.sv
// ----------------------------------------------------------------------------
// fcl_ctrl
// Sequencer: decodes each request and steps the datapath through its walk.
// ----------------------------------------------------------------------------
module fcl_ctrl
    import fcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_cmd,
    input  t_dp_sts    i_dp_sts,
    output t_dp_cmd    o_dp_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;
    localparam logic [2:0] S_POST  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cmd, n_cmd;
    logic [1:0] r_status, n_status;
    logic       r_idx_en, n_idx_en;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_cmd           = r_cmd;
        n_status        = r_status;
        n_idx_en        = r_idx_en;
        o_dp_cmd        = '0;
        o_dp_cmd.op     = DP_NOP;
        o_dp_cmd.cmp_ge = (r_cmd == CMD_SORTED);
        o_dp_cmd.status = r_status;
        o_dp_cmd.idx_en = r_idx_en;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp_cmd.op = DP_LOAD;
                    n_cmd       = i_cmd;
                    n_state     = S_START;
                end
            end
            S_START: begin
                n_status = ST_OK;
                n_idx_en = 1'b0;
                case (r_cmd)
                    CMD_APPEND, CMD_PREPEND: begin
                        if (i_dp_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_POST;
                        end else begin
                            o_dp_cmd.op      = DP_GAP_INIT;
                            o_dp_cmd.pos_sel = (r_cmd == CMD_APPEND) ? PS_TOP : PS_ZERO;
                            n_state          = S_SHIFT;
                        end
                    end
                    CMD_SORTED: begin
                        if (i_dp_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_POST;
                        end else begin
                            o_dp_cmd.op = DP_SCAN_INIT;
                            n_state     = S_SCAN;
                        end
                    end
                    CMD_REMOVE, CMD_SEARCH: begin
                        o_dp_cmd.op = DP_SCAN_INIT;
                        n_state     = S_SCAN;
                    end
                    default: begin
                        n_state = S_POST;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_dp_sts.scan_hit) begin
                    case (r_cmd)
                        CMD_SORTED: begin
                            o_dp_cmd.op      = DP_GAP_INIT;
                            o_dp_cmd.pos_sel = PS_HIT;
                            n_state          = S_SHIFT;
                        end
                        CMD_REMOVE: begin
                            o_dp_cmd.op = DP_TAKE_LAST;
                            n_state     = S_MOVE;
                        end
                        default: begin
                            o_dp_cmd.op = DP_MARK;
                            n_idx_en    = 1'b1;
                            n_state     = S_POST;
                        end
                    endcase
                end else if (i_dp_sts.scan_done) begin
                    case (r_cmd)
                        CMD_SORTED: begin
                            o_dp_cmd.op      = DP_GAP_INIT;
                            o_dp_cmd.pos_sel = PS_TOP;
                            n_state          = S_SHIFT;
                        end
                        CMD_REMOVE: begin
                            n_status = i_dp_sts.any_hit ? ST_OK : ST_MISSING;
                            n_state  = S_POST;
                        end
                        default: begin
                            n_status = ST_MISSING;
                            n_state  = S_POST;
                        end
                    endcase
                end else begin
                    o_dp_cmd.op = DP_SCAN;
                end
            end
            S_SHIFT: begin
                if (i_dp_sts.shift_done) begin
                    o_dp_cmd.op = DP_PLACE;
                    n_state     = S_POST;
                end else begin
                    o_dp_cmd.op = DP_SHIFT;
                end
            end
            S_MOVE: begin
                o_dp_cmd.op = DP_MOVE;
                n_state     = S_SCAN;
            end
            S_POST: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.op = DP_POST;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_idx_en <= n_idx_en;
    end

endmodule

FILE: src/fcl_dpath.sv
// ----------------------------------------------------------------------------
// fcl_dpath
// List memory, entry count, walk pointers and the result register.
// ----------------------------------------------------------------------------
`include "fixed_capacity_list_engine_core_assert.svh"

module fcl_dpath
    import fcl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value,
    input  t_dp_cmd            i_dp_cmd,
    output t_dp_sts            o_dp_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rdata;
    logic [AW-1:0]      r_raddr;
    logic               r_rvld;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_pos;
    logic               r_hit;
    logic               r_cmp_ge;
    logic signed [31:0] r_value;
    logic               r_out_vld;
    t_out               r_out;

    logic [CW-1:0]       w_raddr_ext;
    logic [CW-1:0]       w_ptr_dn;
    logic [CW-1:0]       w_cnt_dn;
    logic [AW-1:0]       w_up;
    logic                w_pending;
    logic                w_match;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [31:0]         w_wdata;
    logic                w_re;
    logic [AW-1:0]       w_rd_addr;
    logic [CW+IDX_W-1:0] w_pos_wide;
    logic [CW+TOT_W-1:0] w_cnt_wide;

    assign w_raddr_ext = CW'(r_raddr);
    assign w_ptr_dn    = r_ptr - CW'(1);
    assign w_cnt_dn    = r_count - CW'(1);
    assign w_up        = r_raddr + AW'(1);
    assign w_pos_wide  = {{IDX_W{1'b0}}, r_pos};
    assign w_cnt_wide  = {{TOT_W{1'b0}}, r_count};

    // an entry in the read register only counts while it lies below the count
    assign w_pending = r_rvld && (w_raddr_ext < r_count);
    assign w_match   = r_cmp_ge ? !($signed(r_rdata) < r_value)
                                : (r_rdata == r_value);

    assign o_dp_sts.full       = (r_count == CNT_DEPTH);
    assign o_dp_sts.scan_hit   = w_pending && w_match;
    assign o_dp_sts.scan_done  = !w_pending && !(r_ptr < r_count);
    assign o_dp_sts.shift_done = !r_rvld && !(r_ptr > r_pos);
    assign o_dp_sts.any_hit    = r_hit;
    assign o_dp_sts.out_free   = !r_out_vld || i_out_ready;

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_pos[AW-1:0];
        w_wdata   = r_rdata;
        w_re      = 1'b0;
        w_rd_addr = r_ptr[AW-1:0];
        case (i_dp_cmd.op)
            DP_SCAN: begin
                w_re      = (r_ptr < r_count);
                w_rd_addr = r_ptr[AW-1:0];
            end
            DP_SHIFT: begin
                w_we      = r_rvld;
                w_waddr   = w_up;
                w_re      = (r_ptr > r_pos);
                w_rd_addr = w_ptr_dn[AW-1:0];
            end
            DP_PLACE: begin
                w_we    = 1'b1;
                w_wdata = r_value;
            end
            DP_TAKE_LAST: begin
                w_re      = 1'b1;
                w_rd_addr = w_cnt_dn[AW-1:0];
            end
            DP_MOVE: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rvld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_dp_cmd.op == DP_POST) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (i_dp_cmd.op)
                DP_LOAD: begin
                    r_value <= i_value;
                end
                DP_SCAN_INIT: begin
                    r_ptr    <= '0;
                    r_pos    <= '0;
                    r_rvld   <= 1'b0;
                    r_hit    <= 1'b0;
                    r_cmp_ge <= i_dp_cmd.cmp_ge;
                end
                DP_SCAN: begin
                    r_rvld <= w_re;
                    if (w_re) begin
                        r_raddr <= r_ptr[AW-1:0];
                        r_ptr   <= r_ptr + CW'(1);
                    end
                end
                DP_GAP_INIT: begin
                    r_ptr  <= r_count;
                    r_rvld <= 1'b0;
                    case (i_dp_cmd.pos_sel)
                        PS_HIT:  r_pos <= w_raddr_ext;
                        PS_TOP:  r_pos <= r_count;
                        default: r_pos <= '0;
                    endcase
                end
                DP_SHIFT: begin
                    r_rvld <= w_re;
                    if (w_re) begin
                        r_raddr <= w_ptr_dn[AW-1:0];
                        r_ptr   <= w_ptr_dn;
                    end
                end
                DP_PLACE: begin
                    r_count <= r_count + CW'(1);
                end
                DP_MARK, DP_TAKE_LAST: begin
                    r_pos <= w_raddr_ext;
                end
                DP_MOVE: begin
                    // moved-in entry sits in the read register: recheck it next
                    r_count <= w_cnt_dn;
                    r_hit   <= 1'b1;
                    r_raddr <= r_pos[AW-1:0];
                    r_rvld  <= 1'b1;
                    r_ptr   <= r_pos + CW'(1);
                end
                DP_POST: begin
                    r_out.status      <= i_dp_cmd.status;
                    r_out.found_index <= i_dp_cmd.idx_en ? w_pos_wide[IDX_W-1:0] : '0;
                    r_out.entry_total <= w_cnt_wide[TOT_W-1:0];
                end
                default: begin
                    r_rvld <= r_rvld;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `FCL_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_DEPTH, "count above capacity")
    `FCL_ASSERT_IMP(a_place_room, i_clk, i_rst_n, i_dp_cmd.op == DP_PLACE, r_count < CNT_DEPTH, "place into full list")
    `FCL_ASSERT_IMP(a_post_slot, i_clk, i_rst_n, i_dp_cmd.op == DP_POST, !r_out_vld || i_out_ready, "result overwritten")
    `FCL_ASSERT_NXT(a_move_recheck, i_clk, i_rst_n, i_dp_cmd.op == DP_MOVE, r_rvld && (r_ptr == r_pos + CW'(1)), "move lost recheck")

endmodule

FILE: src/fixed_capacity_list_engine_core.sv
// ----------------------------------------------------------------------------
// fixed_capacity_list_engine_core
// Ordered list of signed 32-bit values with append, prepend, sorted insert,
// remove-all and search requests; one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_in  (cmd, value)
//  result    out        o_out_valid / i_out_ready  o_out (status, found_index,
//                                                        entry_total)
//
//  Time per request, from one accepted request to the next with the result
//  register free: append does not depend on the entries held; prepend,
//  sorted insert, search and remove walk the list, and remove also moves the
//  last entry into the slot of each match. The single read port of the list
//  memory sets this: walks fetch one entry per cycle, except while a match is moved.
//  Reset (synchronous, active low) empties the list at once; no clearing pass.
//  A posted result waits in its own register; the next request is taken while
//  it waits and stalls only when its own result finds that register occupied.
// ----------------------------------------------------------------------------
module fixed_capacity_list_engine_core
    import fcl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    // control and status between sequencer and datapath
    t_dp_cmd w_dp_cmd;
    t_dp_sts w_dp_sts;

    // sequencer: take the request, walk the list, post the result
    fcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_in.cmd),
        .i_dp_sts   (w_dp_sts),
        .o_dp_cmd   (w_dp_cmd)
    );

    // datapath: hold the list memory, count, walk pointers and result register
    fcl_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.value),
        .i_dp_cmd    (w_dp_cmd),
        .o_dp_sts    (w_dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
